FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, held off while rst_n is low.
`define SGRE_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sgre: assertion failed");

// Condition that must never hold at a clock edge.
`define SGRE_NEVER(name, cond) \
    `SGRE_ASSERT(name, !(cond))

`endif

FILE: rtl/sgre_pkg.sv
package sgre_pkg;

    localparam int MAX_SCALE     = 15;
    localparam int CHAR_ROWS     = 7;
    localparam int GLYPH_COLS    = 5;
    localparam int ADVANCE_CELLS = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_SCALE    = 3'd6;

    localparam logic [7:0] CASE_GAP = 8'h20;

    // Row 0 is the top row; bit 4 of a row is its leftmost column.
    typedef logic [0:CHAR_ROWS-1][GLYPH_COLS-1:0] glyph_t;

    typedef struct packed {
        logic [7:0]  char_code;
        logic        restart;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } in_word_t;

    typedef struct packed {
        logic [9:0]  col_start;
        logic [9:0]  col_end;
        logic [9:0]  row_start;
        logic [9:0]  row_end;
        logic [15:0] fill_color;
        logic [7:0]  pixel_count;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [8:0]  panel_width;
        logic [8:0]  panel_height;
        logic [8:0]  column_offset;
        logic [8:0]  row_offset;
        logic [15:0] fore_color;
        logic [15:0] back_color;
        logic [3:0]  text_scale;
    } cfg_t;

    // One classified character: visible columns and rows with their
    // on-panel origins and clipped extents.
    typedef struct packed {
        glyph_t                                glyph;
        logic [GLYPH_COLS-1:0]                 col_ok;
        logic [CHAR_ROWS-1:0]                  row_ok;
        logic [GLYPH_COLS-1:0][8:0]            col_x;
        logic [CHAR_ROWS-1:0][8:0]             row_y;
        logic [GLYPH_COLS-1:0][3:0]            col_w;
        logic [CHAR_ROWS-1:0][3:0]             row_h;
    } ent_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_ctl_t;

    typedef struct packed {
        logic       not_empty;
        logic       full;
        logic [1:0] count;
    } q_stat_t;

    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        logic [7:0] c;
        glyph_t     g;
        c = code;
        if (c >= "a" && c <= "z")
            c = c - CASE_GAP;
        unique case (c)
            "0": g = {5'h0e, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0e};
            "1": g = {5'h04, 5'h0c, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            "2": g = {5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f};
            "3": g = {5'h1f, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0e};
            "4": g = {5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02};
            "5": g = {5'h1f, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h11, 5'h0e};
            "6": g = {5'h06, 5'h08, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e};
            "7": g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8": g = {5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e};
            "9": g = {5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h02, 5'h0c};
            "A": g = {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            "B": g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e};
            "C": g = {5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e};
            "D": g = {5'h1e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1e};
            "E": g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h1f};
            "F": g = {5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10};
            "G": g = {5'h0e, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0f};
            "H": g = {5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
            "I": g = {5'h0e, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0e};
            "J": g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0c};
            "K": g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L": g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1f};
            "M": g = {5'h11, 5'h1b, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N": g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O": g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            "P": g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h10, 5'h10, 5'h10};
            "Q": g = {5'h0e, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0d};
            "R": g = {5'h1e, 5'h11, 5'h11, 5'h1e, 5'h14, 5'h12, 5'h11};
            "S": g = {5'h0f, 5'h10, 5'h10, 5'h0e, 5'h01, 5'h01, 5'h1e};
            "T": g = {5'h1f, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0e};
            "V": g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0a, 5'h04};
            "W": g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0a};
            "X": g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11, 5'h11};
            "Y": g = {5'h11, 5'h11, 5'h0a, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z": g = {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};
            "-": g = {5'h00, 5'h00, 5'h00, 5'h1f, 5'h00, 5'h00, 5'h00};
            ".": g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0c, 5'h0c};
            "/": g = {5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10};
            ":": g = {5'h00, 5'h0c, 5'h0c, 5'h00, 5'h0c, 5'h0c, 5'h00};
            default: g = '0;
        endcase
        return g;
    endfunction

    function automatic logic [2:0] low_set(input logic [6:0] m);
        logic [2:0] idx;
        idx = '0;
        for (int i = 6; i >= 0; i--)
            if (m[i])
                idx = 3'(i);
        return idx;
    endfunction

    function automatic logic [2:0] high_set(input logic [6:0] m);
        logic [2:0] idx;
        idx = '0;
        for (int i = 0; i < 7; i++)
            if (m[i])
                idx = 3'(i);
        return idx;
    endfunction

    // Lowest set bit strictly above position i.
    function automatic logic [2:0] next_set(input logic [6:0] m, input logic [2:0] i);
        logic [7:0] below;
        below = (8'd2 << i) - 8'd1;
        return low_set(m & ~below[6:0]);
    endfunction

endpackage

FILE: rtl/sgre_front.sv
module sgre_front (
    input  logic               clk,
    input  logic               rst_n,
    input  sgre_pkg::cfg_t     cfg,
    input  logic               char_valid,
    output logic               char_stall,
    input  sgre_pkg::in_word_t char_word,
    input  logic               q_full,
    output logic               push,
    output sgre_pkg::ent_t     ent
);
    import sgre_pkg::*;

    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg;
    logic [15:0] cur_x, cur_y;
    logic [3:0]  scale;
    logic        accept;
    logic [GLYPH_COLS-1:0][15:0] col_pos;
    logic [GLYPH_COLS-1:0][8:0]  col_dx;
    logic [CHAR_ROWS-1:0][15:0]  row_pos;
    logic [CHAR_ROWS-1:0][8:0]   row_dy;

    assign scale = ({4'd0, cfg.text_scale} > 8'(MAX_SCALE)) ? 4'(MAX_SCALE)
                                                            : cfg.text_scale;

    assign cur_x = char_word.restart ? char_word.pos_x : cursor_x_reg;
    assign cur_y = char_word.restart ? char_word.pos_y : cursor_y_reg;

    always_comb
    begin
        ent.glyph = glyph_lookup(char_word.char_code);
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            col_pos[c]  = cur_x + 16'(c) * {12'd0, scale};
            col_dx[c]   = cfg.panel_width - col_pos[c][8:0];
            ent.col_ok[c] = col_pos[c] < {7'd0, cfg.panel_width};
            ent.col_x[c]  = col_pos[c][8:0];
            // clip at the right edge
            ent.col_w[c]  = (col_dx[c] < {5'd0, scale}) ? col_dx[c][3:0] : scale;
        end
        for (int r = 0; r < CHAR_ROWS; r++)
        begin
            row_pos[r]  = cur_y + 16'(r) * {12'd0, scale};
            row_dy[r]   = cfg.panel_height - row_pos[r][8:0];
            ent.row_ok[r] = row_pos[r] < {7'd0, cfg.panel_height};
            ent.row_y[r]  = row_pos[r][8:0];
            ent.row_h[r]  = (row_dy[r] < {5'd0, scale}) ? row_dy[r][3:0] : scale;
        end
    end

    assign char_stall    = q_full;
    assign accept        = char_valid && !q_full;
    // characters with nothing on the panel never reach the queue
    assign push          = accept && (scale != 4'd0) && (|ent.col_ok) && (|ent.row_ok);
    assign cursor_x_next = cur_x + 16'(ADVANCE_CELLS) * {12'd0, scale};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end
        else if (accept)
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cur_y;
        end
    end

endmodule

FILE: rtl/sgre_queue.sv
module sgre_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  sgre_pkg::q_ctl_t  q_ctl,
    input  sgre_pkg::ent_t    wr_ent,
    output sgre_pkg::ent_t    head,
    output sgre_pkg::q_stat_t q_stat
);
    import sgre_pkg::*;

    ent_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head             = slot_reg[rd_ptr_reg];
    assign q_stat.not_empty = count_reg != 2'd0;
    assign q_stat.full      = count_reg == 2'd2;
    assign q_stat.count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (q_ctl.push && !q_ctl.pop)
            count_next = count_reg + 2'd1;
        else if (!q_ctl.push && q_ctl.pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (q_ctl.push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (q_ctl.pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ctl.push)
            slot_reg[wr_ptr_reg] <= wr_ent;
    end

endmodule

FILE: rtl/sgre_back.sv
module sgre_back (
    input  logic                clk,
    input  logic                rst_n,
    input  sgre_pkg::cfg_t      cfg,
    input  sgre_pkg::ent_t      head,
    input  sgre_pkg::q_stat_t   q_stat,
    output logic                pop,
    output logic                rect_valid,
    input  logic                rect_stall,
    output sgre_pkg::out_word_t rect_word
);
    import sgre_pkg::*;

    logic       rect_valid_reg, rect_valid_next;
    logic       started_reg;
    logic [2:0] row_reg, col_reg;
    out_word_t  word_reg, word_next;
    logic [6:0] col_mask;
    logic [2:0] first_row, last_row, first_col, last_col;
    logic [2:0] cur_r, cur_c, next_r, next_c;
    logic [8:0] x, y;
    logic [3:0] w, h;
    logic       is_last, advance;

    assign col_mask  = {2'b00, head.col_ok};
    assign first_row = low_set(head.row_ok);
    assign last_row  = high_set(head.row_ok);
    assign first_col = low_set(col_mask);
    assign last_col  = high_set(col_mask);

    // a fresh character starts at its first visible cell
    assign cur_r = started_reg ? row_reg : first_row;
    assign cur_c = started_reg ? col_reg : first_col;

    assign x = head.col_x[cur_c];
    assign w = head.col_w[cur_c];
    assign y = head.row_y[cur_r];
    assign h = head.row_h[cur_r];

    assign is_last = (cur_r == last_row) && (cur_c == last_col);
    assign advance = q_stat.not_empty && (!rect_valid_reg || !rect_stall);
    assign pop     = advance && is_last;

    always_comb
    begin
        if (cur_c == last_col)
        begin
            next_r = next_set(head.row_ok, cur_r);
            next_c = first_col;
        end
        else
        begin
            next_r = cur_r;
            next_c = next_set(col_mask, cur_c);
        end
    end

    always_comb
    begin
        word_next.col_start   = 10'(cfg.column_offset) + 10'(x);
        word_next.col_end     = 10'(cfg.column_offset) + 10'(x) + 10'(w) - 10'd1;
        word_next.row_start   = 10'(cfg.row_offset) + 10'(y);
        word_next.row_end     = 10'(cfg.row_offset) + 10'(y) + 10'(h) - 10'd1;
        word_next.fill_color  = head.glyph[cur_r][3'd4 - cur_c] ? cfg.fore_color
                                                                : cfg.back_color;
        word_next.pixel_count = {4'd0, w} * {4'd0, h};
        word_next.last        = is_last;
    end

    always_comb
    begin
        rect_valid_next = rect_valid_reg && rect_stall;
        if (advance)
            rect_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_valid_reg <= 1'b0;
            started_reg    <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
        end
        else
        begin
            rect_valid_reg <= rect_valid_next;
            if (advance)
            begin
                started_reg <= !is_last;
                row_reg     <= next_r;
                col_reg     <= next_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            word_reg <= word_next;
    end

    assign rect_valid = rect_valid_reg;
    assign rect_word  = word_reg;

endmodule

FILE: rtl/scaled_glyph_rect_expander_top.sv
// Draws 5x7 text as filled windows: each character word on the char channel
// becomes one window word per visible glyph cell on the rect channel, row by
// row and left to right, the final one flagged last. The front end takes a
// character every cycle while its two-entry queue has room, looks up the
// glyph, updates the cursor and clips all five columns and seven rows at once;
// a character with no visible cell (or text_scale of zero) leaves the queue
// untouched. The back end sequencer emits one window per clock while
// rect_stall is low, so a character yields visible rows times visible columns
// windows, 1 to 35, and it sets the sustained rate. Its output is registered.
// The user must write configuration only while idle; nothing enforces it.
`include "assert_macros.svh"

module scaled_glyph_rect_expander_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sgre_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sgre_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              char_valid,
    output logic                              char_stall,
    input  sgre_pkg::in_word_t                char_word,
    output logic                              rect_valid,
    input  logic                              rect_stall,
    output sgre_pkg::out_word_t               rect_word
);
    import sgre_pkg::*;

    cfg_t    cfg_reg;
    ent_t    wr_ent, head;
    q_ctl_t  q_ctl;
    q_stat_t q_stat;
    logic    push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.panel_width   <= 9'd240;
            cfg_reg.panel_height  <= 9'd320;
            cfg_reg.column_offset <= '0;
            cfg_reg.row_offset    <= '0;
            cfg_reg.fore_color    <= 16'hffff;
            cfg_reg.back_color    <= '0;
            cfg_reg.text_scale    <= 4'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PANEL_WIDTH:   cfg_reg.panel_width   <= cfg_data[8:0];
                REG_PANEL_HEIGHT:  cfg_reg.panel_height  <= cfg_data[8:0];
                REG_COLUMN_OFFSET: cfg_reg.column_offset <= cfg_data[8:0];
                REG_ROW_OFFSET:    cfg_reg.row_offset    <= cfg_data[8:0];
                REG_FORE_COLOR:    cfg_reg.fore_color    <= cfg_data;
                REG_BACK_COLOR:    cfg_reg.back_color    <= cfg_data;
                REG_TEXT_SCALE:    cfg_reg.text_scale    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    sgre_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_word  (char_word),
        .q_full     (q_stat.full),
        .push       (push),
        .ent        (wr_ent)
    );

    assign q_ctl.push = push;
    assign q_ctl.pop  = pop;

    sgre_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_ctl  (q_ctl),
        .wr_ent (wr_ent),
        .head   (head),
        .q_stat (q_stat)
    );

    sgre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .rect_valid (rect_valid),
        .rect_stall (rect_stall),
        .rect_word  (rect_word)
    );

    `SGRE_ASSERT(a_no_word_from_empty, !q_stat.not_empty && !rect_valid |=> !rect_valid)
    `SGRE_NEVER(a_pop_when_empty, q_ctl.pop && !q_stat.not_empty)
    `SGRE_NEVER(a_count_overrun, q_stat.count == 2'd3)

endmodule
